FILE: sv/scan_potential_field_steering_top_macros.svh
// Assertion macros for the scan potential field steering block
`ifndef SCAN_POTENTIAL_FIELD_STEERING_TOP_MACROS_SVH
`define SCAN_POTENTIAL_FIELD_STEERING_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define SPF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define SPF_ASSERT(lbl, clk, rstn, prop)
`define SPF_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: sv/spf_pkg.sv
// Shared types, constants and tables for the scan potential field steering block
package spf_pkg;
  localparam int unsigned MaxBeamsDef = 2048;
  localparam logic signed [23:0] PiQ = 24'sd3294199;
  localparam logic signed [23:0] TwoPiQ = 24'sd6588397;
  localparam logic signed [23:0] HalfPiQ = 24'sd1647099;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam int unsigned CordicN = 20;
  localparam logic signed [39:0] SumMax = 40'sd549755813887;

  localparam logic signed [22:0] StartAngleRst = -23'sd3294199;
  localparam logic [15:0] AngleStepRst = 16'd6588;
  localparam logic [14:0] BaseSpeedRst = 15'd4915;
  localparam logic [3:0] TurnGainRst = 4'd10;

  localparam logic [1:0] RegStartAngle = 2'd0;
  localparam logic [1:0] RegAngleStep = 2'd1;
  localparam logic [1:0] RegBaseSpeed = 2'd2;
  localparam logic [1:0] RegTurnGain = 2'd3;

  typedef struct packed {
    logic signed [22:0] start_angle;
    logic [15:0] angle_step;
    logic [14:0] base_speed;
    logic [3:0] turn_gain;
  } cfg_t;

  function automatic logic signed [23:0] atan_lut(input logic [4:0] i);
    logic signed [23:0] r;
    begin
      unique case (i)
        5'd0: r = 24'sd823550;
        5'd1: r = 24'sd486170;
        5'd2: r = 24'sd256879;
        5'd3: r = 24'sd130396;
        5'd4: r = 24'sd65451;
        5'd5: r = 24'sd32757;
        5'd6: r = 24'sd16383;
        5'd7: r = 24'sd8192;
        5'd8: r = 24'sd4096;
        5'd9: r = 24'sd2048;
        5'd10: r = 24'sd1024;
        5'd11: r = 24'sd512;
        5'd12: r = 24'sd256;
        5'd13: r = 24'sd128;
        5'd14: r = 24'sd64;
        5'd15: r = 24'sd32;
        5'd16: r = 24'sd16;
        5'd17: r = 24'sd8;
        5'd18: r = 24'sd4;
        5'd19: r = 24'sd2;
        default: r = 24'sd0;
      endcase
      return r;
    end
  endfunction
endpackage

FILE: sv/spf_divu.sv
// Bit-serial restoring divider, one quotient bit per cycle
module spf_divu #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DenW:0] trial;
  logic [DenW:0] shifted;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
    trial = shifted - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

FILE: sv/spf_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle
module spf_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import spf_pkg::*;

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [24:0] z_q, z_d;
  logic [4:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic signed [33:0] dx, dy;
  logic signed [24:0] zr;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    it_d = it_q;
    busy_d = busy_q;
    neg_d = neg_q;
    done_d = 1'b0;
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    zr = {angle_i[23], angle_i};
    if (start_i) begin
      x_d = CordicK;
      y_d = '0;
      it_d = '0;
      busy_d = 1'b1;
      neg_d = 1'b0;
      if (zr > 25'(HalfPiQ)) begin
        zr = zr - 25'(PiQ);
        neg_d = 1'b1;
      end else if (zr < -25'(HalfPiQ)) begin
        zr = zr + 25'(PiQ);
        neg_d = 1'b1;
      end
      z_d = zr;
    end else if (busy_q) begin
      if (!z_q[24]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - 25'(atan_lut(it_q));
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + 25'(atan_lut(it_q));
      end
      it_d = it_q + 1'b1;
      if (it_q == 5'(CordicN - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign cos_o = neg_q ? -x_q : x_q;
  assign sin_o = neg_q ? -y_q : y_q;
endmodule

FILE: sv/scan_potential_field_steering_top.sv
// Scan potential field steering: beam accumulation and per-scan speed commands
// A plain beam holds the input until the 40-step weight divide completes;
// angle reduce (6 steps) and CORDIC (20 steps) run alongside it.
// A last beam adds two 40-step average divides in sequence before its command appears;
// a waiting command stalls only the next scan end.
// Reset clears sums, beam index, flags and out_valid_o; registers take defaults.
module scan_potential_field_steering_top #(
  parameter int unsigned MaxBeams = spf_pkg::MaxBeamsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] beam_range_i,
  input  logic        last_beam_i,
  input  logic        stop_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] linear_speed_o,
  output logic signed [18:0] angular_rate_o,
  output logic        halted_o
);
  import spf_pkg::*;
  `include "scan_potential_field_steering_top_macros.svh"

  localparam int unsigned IdxW = 12;

  typedef enum logic [5:0] {
    StIdle = 6'b000001, StBeam = 6'b000010, StAcc = 6'b000100,
    StDivF = 6'b001000, StDivS = 6'b010000, StOut = 6'b100000
  } state_e;

  state_e st_q, st_d;
  cfg_t cfg_q;
  logic [IdxW-1:0] idx_q;
  logic signed [39:0] fsum_q, ssum_q;
  logic issued_q, pend_q, halt_q, last_q;
  logic trig_ok_q, w_ok_q;
  logic signed [33:0] cos_q, sin_q;
  logic [16:0] w_q;
  logic signed [39:0] fav_q, sav_q;
  logic [IdxW:0] cnt_q;
  logic ov_q;
  logic [15:0] lin_q;
  logic signed [18:0] ang_q;
  logic hl_q;

  logic accept, start_b, ov_free;
  logic [27:0] ang_prod;
  logic signed [29:0] ang_full;
  logic [28:0] red_q, red_d, red_sub;
  logic [2:0] rsh_q, rsh_d;
  logic red_busy_q, red_busy_d, c_start_q, c_start_d;
  logic signed [23:0] ang_red;
  logic c_done, d_done;
  logic signed [33:0] c_cos, c_sin;
  logic d_start;
  logic [39:0] d_num;
  logic [32:0] d_den;
  logic [39:0] d_quo;
  logic [32:0] den_w;
  logic signed [39:0] nf_sat;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign start_b = accept && !halt_q;
  assign ov_free = !ov_q || !out_stall_i;

  // angle = start + idx*step, reduced into [0, 2pi) by compare-subtract of 2pi << 5..0
  assign ang_prod = 28'(idx_q) * 28'(cfg_q.angle_step);
  assign ang_full = 30'(cfg_q.start_angle) + $signed({2'b0, ang_prod});

  always_comb begin
    red_d = red_q;
    rsh_d = rsh_q;
    red_busy_d = red_busy_q;
    c_start_d = 1'b0;
    red_sub = 29'(TwoPiQ) << rsh_q;
    if (start_b) begin
      red_d = ang_full[29] ? 29'(ang_full + 30'(TwoPiQ)) : 29'(ang_full);
      rsh_d = 3'd5;
      red_busy_d = 1'b1;
    end else if (red_busy_q) begin
      if (red_q >= red_sub) red_d = red_q - red_sub;
      rsh_d = rsh_q - 1'b1;
      if (rsh_q == '0) begin
        red_busy_d = 1'b0;
        c_start_d = 1'b1;
      end
    end
  end

  assign ang_red = (red_q > 29'(PiQ)) ? 24'(red_q - 29'(TwoPiQ)) : 24'(red_q);

  spf_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(c_start_q), .angle_i(ang_red),
    .done_o(c_done), .cos_o(c_cos), .sin_o(c_sin)
  );

  assign den_w = 33'(beam_range_i) * 33'(beam_range_i) + 33'd65536;

  logic [IdxW:0] cnt_now;
  assign cnt_now = {1'b0, idx_q} + 1'b1;

  always_comb begin
    d_start = 1'b0;
    d_num = 40'd1 << 32;
    d_den = den_w;
    if (start_b) begin
      d_start = 1'b1;
      d_num = (40'd1 << 32) + 40'(den_w >> 1);
    end else if (st_q == StAcc && last_q) begin
      d_start = 1'b1;
      d_num = nf_sat[39] ? 40'(-nf_sat) : 40'(nf_sat);
      d_den = 33'(cnt_now);
    end else if (st_q == StDivF && d_done) begin
      d_start = 1'b1;
      d_num = ssum_q[39] ? 40'(-ssum_q) : 40'(ssum_q);
      d_den = 33'(cnt_q);
    end
  end

  spf_divu #(.NumW(40), .DenW(33)) u_div (
    .clk_i, .rst_ni, .start_i(d_start), .num_i(d_num), .den_i(d_den),
    .done_o(d_done), .quo_o(d_quo)
  );

  // term products, each a 34x17 multiply
  logic signed [51:0] pf, ps;
  logic signed [39:0] tf, ts;
  logic signed [41:0] nf, ns;
  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    if (v > 42'(SumMax)) return SumMax;
    if (v < -42'(SumMax)) return -SumMax;
    return 40'(v);
  endfunction
  assign pf = cos_q * $signed({1'b0, w_q});
  assign ps = sin_q * $signed({1'b0, w_q});
  assign tf = 40'(pf >>> 19);
  assign ts = 40'(ps >>> 19);
  assign nf = 42'(fsum_q) - 42'(tf);
  assign ns = 42'(ssum_q) - 42'(ts);
  assign nf_sat = sat40(nf);

  logic signed [39:0] sav;
  logic signed [26:0] lin_s, ang_s;
  logic signed [31:0] ang_m;
  logic signed [16:0] lim;
  assign sav = ssum_q[39] ? -$signed(d_quo) : $signed(d_quo);
  always_comb begin
    lim = {2'b0, cfg_q.base_speed};
    lin_s = 27'(fav_q >>> 13);
    if (lin_s > 27'(lim)) lin_s = 27'(lim);
    if (lin_s < -27'(lim)) lin_s = -27'(lim);
    ang_s = 27'(sav_q >>> 13);
    ang_m = 32'(ang_s) * $signed({28'd0, cfg_q.turn_gain});
    if (ang_m > 32'sd262143) ang_m = 32'sd262143;
    if (ang_m < -32'sd262144) ang_m = -32'sd262144;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (start_b) st_d = StBeam;
      StBeam: if (trig_ok_q && w_ok_q) st_d = StAcc;
      StAcc: st_d = last_q ? StDivF : StIdle;
      StDivF: if (d_done) st_d = StDivS;
      StDivS: if (d_done) st_d = StOut;
      StOut: if (ov_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cfg_q <= '{StartAngleRst, AngleStepRst, BaseSpeedRst, TurnGainRst};
      idx_q <= '0;
      fsum_q <= '0;
      ssum_q <= '0;
      issued_q <= 1'b0;
      pend_q <= 1'b0;
      halt_q <= 1'b0;
      ov_q <= 1'b0;
      trig_ok_q <= 1'b0;
      w_ok_q <= 1'b0;
      last_q <= 1'b0;
      rsh_q <= '0;
      red_busy_q <= 1'b0;
      c_start_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rsh_q <= rsh_d;
      red_busy_q <= red_busy_d;
      c_start_q <= c_start_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegStartAngle: cfg_q.start_angle <= cfg_data_i;
          RegAngleStep: cfg_q.angle_step <= cfg_data_i[15:0];
          RegBaseSpeed: cfg_q.base_speed <= cfg_data_i[14:0];
          RegTurnGain: cfg_q.turn_gain <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (start_b) begin
        last_q <= last_beam_i;
        trig_ok_q <= 1'b0;
        w_ok_q <= 1'b0;
        if (stop_request_i && issued_q) pend_q <= 1'b1;
      end
      if (c_done) trig_ok_q <= 1'b1;
      if (st_q == StBeam && d_done) w_ok_q <= 1'b1;
      if (st_q == StAcc) begin
        fsum_q <= nf_sat;
        ssum_q <= sat40(ns);
        if (idx_q < IdxW'(MaxBeams - 1)) idx_q <= idx_q + 1'b1;
      end
      if (st_q == StDivS && d_done) begin
        idx_q <= '0;
        fsum_q <= '0;
        ssum_q <= '0;
      end
      if (st_q == StOut && ov_free) begin
        ov_q <= 1'b1;
        if (pend_q) halt_q <= 1'b1;
        else issued_q <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    if (c_done) begin
      cos_q <= c_cos;
      sin_q <= c_sin;
    end
    if (st_q == StBeam && d_done) w_q <= d_quo[16:0];
    if (st_q == StAcc) cnt_q <= cnt_now;
    if (st_q == StDivF && d_done) fav_q <= fsum_q[39] ? -$signed(d_quo) : $signed(d_quo);
    if (st_q == StDivS && d_done) sav_q <= sav;
    if (st_q == StOut && ov_free) begin
      if (pend_q) begin
        lin_q <= '0;
        ang_q <= '0;
        hl_q <= 1'b1;
      end else begin
        lin_q <= 16'(lim + 17'(lin_s));
        ang_q <= 19'(ang_m);
        hl_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign linear_speed_o = lin_q;
  assign angular_rate_o = ang_q;
  assign halted_o = hl_q;

  `SPF_ASSERT(a_stall_busy, clk_i, rst_ni, (st_q != StIdle) |-> in_stall_o)
  `SPF_ASSERT(a_halt_quiet, clk_i, rst_ni, $past(halt_q) && halt_q |-> !$rose(ov_q))
  `SPF_ASSERT(a_onehot, clk_i, rst_ni, $onehot(st_q))
  `SPF_ASSERT(a_out_after_div, clk_i, rst_ni, $rose(ov_q) |-> $past(st_q == StOut))
endmodule
